// ----- hdl/mixed_radix_index_convert_unit_defines.svh -----
// Assertion helpers shared by the converter RTL.
`ifndef MIXED_RADIX_INDEX_CONVERT_UNIT_DEFINES_SVH
`define MIXED_RADIX_INDEX_CONVERT_UNIT_DEFINES_SVH

// same-cycle implication
`define MRIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MRIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mric_pkg.sv -----
package mric_pkg;

  localparam int NUM_COORDS    = 8;
  localparam int SLOT_BITS     = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_RANK         = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAJOR_ORDER  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_TOTAL_SIZE   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_EXTENTS_LOW  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_EXTENTS_HIGH = 3'd4;

  localparam logic [63:0] EXTENTS_RESET = 64'd281479271743489;

  typedef struct packed {
    logic [3:0]                                rank;
    logic                                      major_order;
    logic [31:0]                               total_size;
    logic [NUM_COORDS-1:0][SLOT_BITS-1:0]      extents;
  } mric_cfg_t;

endpackage

// ----- hdl/mric_axis.sv -----
`include "mixed_radix_index_convert_unit_defines.svh"

module mric_axis #(
  parameter int POS         = 0,
  parameter int EXTENT_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          adv,
  input  mric_pkg::mric_cfg_t                           cfg,
  input  logic                                          in_v,
  input  logic                                          in_kind,
  input  logic [INDEX_BITS-1:0]                         in_idx,
  input  logic [mric_pkg::NUM_COORDS-1:0][EXTENT_BITS-1:0] in_cin,
  input  logic [mric_pkg::NUM_COORDS-1:0][EXTENT_BITS-1:0] in_cout,
  input  logic [INDEX_BITS-1:0]                         in_sum,
  input  logic [INDEX_BITS-1:0]                         in_stride,
  input  logic                                          in_flag,
  output logic                                          out_v,
  output logic                                          out_kind,
  output logic [INDEX_BITS-1:0]                         out_idx,
  output logic [mric_pkg::NUM_COORDS-1:0][EXTENT_BITS-1:0] out_cin,
  output logic [mric_pkg::NUM_COORDS-1:0][EXTENT_BITS-1:0] out_cout,
  output logic [INDEX_BITS-1:0]                         out_sum,
  output logic [INDEX_BITS-1:0]                         out_stride,
  output logic                                          out_flag
);
  import mric_pkg::*;

  localparam int EB  = EXTENT_BITS;
  localparam int IB  = INDEX_BITS;
  localparam int BPS = 4;
  localparam int NS  = (IB + BPS - 1) / BPS;
  localparam int CW  = (IB > EB) ? IB : EB;
  localparam logic [3:0]    POS_C = 4'(POS);
  localparam logic [EB-1:0] EMAX  = {EB{1'b1}};

  logic          in_use, divides, is_top;
  logic [2:0]    ax;
  logic [EB-1:0] e, e_adj;

  always_comb begin
    in_use  = POS_C < cfg.rank;
    divides = (POS_C + 4'd1) < cfg.rank;
    is_top  = (POS_C + 4'd1) == cfg.rank;
    ax      = cfg.major_order ? 3'(cfg.rank - 4'd1 - POS_C) : POS_C[2:0];
    e       = cfg.extents[ax][EB-1:0];
    e_adj   = (e == '0) ? EB'(1) : e;
  end

  logic                               v      [NS+1];
  logic                               kind   [NS+1];
  logic [IB-1:0]                      idx    [NS+1];
  logic [IB-1:0]                      acc    [NS+1];
  logic [EB-1:0]                      pr     [NS+1];
  logic [IB-1:0]                      sum    [NS+1];
  logic [IB-1:0]                      stride [NS+1];
  logic [IB-1:0]                      prod   [NS+1];
  logic [IB-1:0]                      snx    [NS+1];
  logic [NUM_COORDS-1:0][EB-1:0]      cin    [NS+1];
  logic [NUM_COORDS-1:0][EB-1:0]      cout   [NS+1];
  logic                               flag   [NS+1];

  assign v[0]      = in_v;
  assign kind[0]   = in_kind;
  assign idx[0]    = in_idx;
  assign acc[0]    = in_idx;
  assign pr[0]     = '0;
  assign sum[0]    = in_sum;
  assign stride[0] = in_stride;
  assign prod[0]   = '0;
  assign snx[0]    = '0;
  assign cin[0]    = in_cin;
  assign cout[0]   = in_cout;
  assign flag[0]   = in_flag;

  for (genvar s = 0; s < NS; s++) begin : g_sub
    logic [IB-1:0]                 idx_n, acc_n, sum_n, stride_n, prod_n, snx_n;
    logic [EB-1:0]                 pr_n;
    logic [NUM_COORDS-1:0][EB-1:0] cout_n;
    logic                          flag_n;

    always_comb begin
      logic [EB:0]   r2;
      logic          q;
      logic [CW-1:0] idx_w;
      acc_n    = acc[s];
      pr_n     = pr[s];
      idx_n    = idx[s];
      sum_n    = sum[s];
      stride_n = stride[s];
      prod_n   = prod[s];
      snx_n    = snx[s];
      cout_n   = cout[s];
      flag_n   = flag[s];
      r2       = '0;
      q        = 1'b0;
      idx_w    = CW'(idx[s]);
      // restoring division, BPS quotient bits per stage
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < IB) begin
          r2    = {pr_n, acc_n[IB-1]};
          q     = r2 >= {1'b0, e_adj};
          acc_n = {acc_n[IB-2:0], q};
          pr_n  = q ? EB'(r2 - {1'b0, e_adj}) : r2[EB-1:0];
        end
      end
      if (s == 0) begin
        prod_n = IB'(cin[s][ax] * stride[s]);
        snx_n  = IB'(stride[s] * e_adj);
        if (kind[s] && in_use && (e == '0 || cin[s][ax] >= e)) flag_n = 1'b1;
      end
      if (s == 1) begin
        if (in_use) begin
          sum_n    = sum[s] + prod[s];
          stride_n = snx[s];
        end
      end
      if (s == NS - 1) begin
        if (!kind[s] && divides) begin
          cout_n[ax] = pr_n;
          idx_n      = acc_n;
          if (e == '0) flag_n = 1'b1;
        end else if (!kind[s] && is_top) begin
          cout_n[ax] = (idx_w > CW'(EMAX)) ? EMAX : idx_w[EB-1:0];
          if (e == '0 || idx_w >= CW'(e)) flag_n = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kind[s+1]   <= kind[s];
        idx[s+1]    <= idx_n;
        acc[s+1]    <= acc_n;
        pr[s+1]     <= pr_n;
        sum[s+1]    <= sum_n;
        stride[s+1] <= stride_n;
        prod[s+1]   <= prod_n;
        snx[s+1]    <= snx_n;
        cin[s+1]    <= cin[s];
        cout[s+1]   <= cout_n;
        flag[s+1]   <= flag_n;
      end
    end
  end

  assign out_v      = v[NS];
  assign out_kind   = kind[NS];
  assign out_idx    = idx[NS];
  assign out_cin    = cin[NS];
  assign out_cout   = cout[NS];
  assign out_sum    = sum[NS];
  assign out_stride = stride[NS];
  assign out_flag   = flag[NS];

  `MRIC_ASSERT_NXT(a_hold, out_v && !adv, out_v, "axis stage lost an item under stall")
  `MRIC_ASSERT_NXT(a_data_hold, out_v && !adv, $stable(out_idx) && $stable(out_flag), "item changed")
  `MRIC_ASSERT_NXT(a_coord_hold, out_v && !adv, $stable(out_cout) && $stable(out_sum), "coords changed")

endmodule

// ----- hdl/mixed_radix_index_convert_unit.sv -----
// Mixed-radix index converter.
// Input channel (in_valid/in_ready): kind 0 splits linear_index into per-axis
// coordinates, kind 1 folds coord_0..coord_7 into a flat index. Output channel
// (out_valid/out_ready) returns result_index, result_coord_0..7 and
// out_of_range, one result per item, in order.
// Shape comes from the write port (cfg_we, cfg_index, cfg_wdata); write it only
// while no items are in flight.
// Throughput: one item per cycle while in_ready is high. Each axis runs one
// radix-2 divider of INDEX_BITS steps, four quotient bits per stage; the
// multiply-accumulate of kind 1 rides in the same stages.
// The output is a two-entry buffer; the pipeline and in_ready stall only when
// both entries hold results the receiver has not taken.
// Reset (rst, synchronous) empties the pipeline and output buffer and loads
// rank 1, major_order 0, total_size 1 and all extents 1.
`include "mixed_radix_index_convert_unit_defines.svh"

module mixed_radix_index_convert_unit #(
  parameter int MAX_RANK    = 8,
  parameter int EXTENT_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mric_pkg::REG_IDX_BITS-1:0]     cfg_index,
  input  logic [mric_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [INDEX_BITS-1:0]                 linear_index,
  input  logic [EXTENT_BITS-1:0]                coord_0,
  input  logic [EXTENT_BITS-1:0]                coord_1,
  input  logic [EXTENT_BITS-1:0]                coord_2,
  input  logic [EXTENT_BITS-1:0]                coord_3,
  input  logic [EXTENT_BITS-1:0]                coord_4,
  input  logic [EXTENT_BITS-1:0]                coord_5,
  input  logic [EXTENT_BITS-1:0]                coord_6,
  input  logic [EXTENT_BITS-1:0]                coord_7,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [INDEX_BITS-1:0]                 result_index,
  output logic [EXTENT_BITS-1:0]                result_coord_0,
  output logic [EXTENT_BITS-1:0]                result_coord_1,
  output logic [EXTENT_BITS-1:0]                result_coord_2,
  output logic [EXTENT_BITS-1:0]                result_coord_3,
  output logic [EXTENT_BITS-1:0]                result_coord_4,
  output logic [EXTENT_BITS-1:0]                result_coord_5,
  output logic [EXTENT_BITS-1:0]                result_coord_6,
  output logic [EXTENT_BITS-1:0]                result_coord_7,
  output logic                                  out_of_range
);
  import mric_pkg::*;

  localparam int EB = EXTENT_BITS;
  localparam int IB = INDEX_BITS;
  localparam int NR = MAX_RANK;
  localparam logic [3:0] MAX_RANK_C = 4'(MAX_RANK);

  logic [3:0]  rank;
  logic        major_order;
  logic [31:0] total_size;
  logic [63:0] extents_low;
  logic [63:0] extents_high;
  mric_cfg_t   cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank         <= 4'd1;
      major_order  <= 1'b0;
      total_size   <= 32'd1;
      extents_low  <= EXTENTS_RESET;
      extents_high <= EXTENTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANK:         rank         <= cfg_wdata[3:0];
        REG_MAJOR_ORDER:  major_order  <= cfg_wdata[0];
        REG_TOTAL_SIZE:   total_size   <= cfg_wdata[31:0];
        REG_EXTENTS_LOW:  extents_low  <= cfg_wdata;
        REG_EXTENTS_HIGH: extents_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rank        = (rank == 4'd0) ? 4'd1 : ((rank > MAX_RANK_C) ? MAX_RANK_C : rank);
    cfg.major_order = major_order;
    cfg.total_size  = total_size;
    cfg.extents     = {extents_high, extents_low};
  end

  logic                          adv;
  logic [1:0]                    cnt;

  // input register
  logic                          c_v      [NR+1];
  logic                          c_kind   [NR+1];
  logic [IB-1:0]                 c_idx    [NR+1];
  logic [NUM_COORDS-1:0][EB-1:0] c_cin    [NR+1];
  logic [NUM_COORDS-1:0][EB-1:0] c_cout   [NR+1];
  logic [IB-1:0]                 c_sum    [NR+1];
  logic [IB-1:0]                 c_stride [NR+1];
  logic                          c_flag   [NR+1];

  assign adv      = cnt != 2'd2;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_kind[0]   <= kind;
      c_idx[0]    <= linear_index;
      c_cin[0]    <= {coord_7, coord_6, coord_5, coord_4,
                      coord_3, coord_2, coord_1, coord_0};
      c_cout[0]   <= '0;
      c_sum[0]    <= '0;
      c_stride[0] <= IB'(1);
      c_flag[0]   <= !kind && (32'(linear_index) >= total_size);
    end
  end

  for (genvar p = 0; p < NR; p++) begin : g_axis
    mric_axis #(
      .POS         (p),
      .EXTENT_BITS (EB),
      .INDEX_BITS  (IB)
    ) u_axis (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cfg        (cfg),
      .in_v       (c_v[p]),
      .in_kind    (c_kind[p]),
      .in_idx     (c_idx[p]),
      .in_cin     (c_cin[p]),
      .in_cout    (c_cout[p]),
      .in_sum     (c_sum[p]),
      .in_stride  (c_stride[p]),
      .in_flag    (c_flag[p]),
      .out_v      (c_v[p+1]),
      .out_kind   (c_kind[p+1]),
      .out_idx    (c_idx[p+1]),
      .out_cin    (c_cin[p+1]),
      .out_cout   (c_cout[p+1]),
      .out_sum    (c_sum[p+1]),
      .out_stride (c_stride[p+1]),
      .out_flag   (c_flag[p+1])
    );
  end

  // result formatting
  logic [IB-1:0]                 new_index;
  logic [NUM_COORDS-1:0][EB-1:0] new_coords;
  logic                          new_flag;

  always_comb begin
    new_index  = c_kind[NR] ? c_sum[NR] : '0;
    new_coords = c_kind[NR] ? '0 : c_cout[NR];
    new_flag   = c_flag[NR] || (c_kind[NR] && (32'(c_sum[NR]) >= total_size));
  end

  // two-entry output buffer
  logic [IB-1:0]                 hd_index, tl_index;
  logic [NUM_COORDS-1:0][EB-1:0] hd_coords, tl_coords;
  logic                          hd_flag, tl_flag;
  logic                          push, pop;
  logic [1:0]                    slot;

  assign pop  = (cnt != 2'd0) && out_ready;
  assign push = adv && c_v[NR];
  assign slot = 2'(cnt - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      hd_index  <= tl_index;
      hd_coords <= tl_coords;
      hd_flag   <= tl_flag;
    end
    if (push) begin
      if (slot == 2'd0) begin
        hd_index  <= new_index;
        hd_coords <= new_coords;
        hd_flag   <= new_flag;
      end else begin
        tl_index  <= new_index;
        tl_coords <= new_coords;
        tl_flag   <= new_flag;
      end
    end
  end

  assign out_valid      = cnt != 2'd0;
  assign result_index   = hd_index;
  assign result_coord_0 = hd_coords[0];
  assign result_coord_1 = hd_coords[1];
  assign result_coord_2 = hd_coords[2];
  assign result_coord_3 = hd_coords[3];
  assign result_coord_4 = hd_coords[4];
  assign result_coord_5 = hd_coords[5];
  assign result_coord_6 = hd_coords[6];
  assign result_coord_7 = hd_coords[7];
  assign out_of_range   = hd_flag;

  `MRIC_ASSERT_IMP(a_full_stall, cnt == 2'd2, !in_ready, "accepting while output buffer full")
  `MRIC_ASSERT_IMP(a_kind_excl, out_valid && result_index != '0, result_coord_0 == '0, "index and coords both set")
  `MRIC_ASSERT_NXT(a_tail_hold, c_v[NR] && !adv, c_v[NR], "pipeline dropped item under stall")

endmodule
